// ===== hdl/barometric_pressure_compensation_assert.svh =====
// Assertion macros for the barometric pressure compensation block.
// Used by barometric_pressure_compensation.sv in this folder; no other dependencies.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define BPC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpc assertion failed");

// Antecedent implies consequent in the next cycle.
`define BPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpc assertion failed");

`endif

// ===== hdl/bpc_pkg.sv =====
// Shared types, constants and helpers for the pressure compensation block.
// No dependencies.
package bpc_pkg;

   localparam int DIV_W      = 32;
   localparam int DIV_STAGES = DIV_W;
   localparam int SIDE_W     = 64;
   // Register stages from an accepted word to its result strobe.
   localparam int LATENCY    = 2 * DIV_STAGES + 10;

   localparam logic [2:0] CSR_AC1     = 3'd0;
   localparam logic [2:0] CSR_AC2     = 3'd1;
   localparam logic [2:0] CSR_AC3     = 3'd2;
   localparam logic [2:0] CSR_AC4     = 3'd3;
   localparam logic [2:0] CSR_AC5_AC6 = 3'd4;
   localparam logic [2:0] CSR_B1_B2   = 3'd5;
   localparam logic [2:0] CSR_MC_MD   = 3'd6;
   localparam logic [2:0] CSR_OSS     = 3'd7;

   typedef struct packed {
      logic [18:0] raw_pressure;
      logic [15:0] raw_temperature;
   } req_type;

   typedef struct packed {
      logic signed [15:0] temp_tenths;
      logic [19:0]        pressure_pa;
      logic               status;
   } rsp_type;

   // Sideband carried alongside the temperature divider.
   typedef struct packed {
      logic [10:0] pad;
      logic [31:0] x1;
      logic [18:0] up;
      logic        neg;
      logic        zero;
   } tside_type;

   // Sideband carried alongside the pressure divider.
   typedef struct packed {
      logic [44:0] pad;
      logic [15:0] temp;
      logic        t_zero;
      logic        big;
      logic        p_zero;
   } pside_type;

   function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
      return 32'($signed(v) >>> n);
   endfunction

endpackage

// ===== hdl/bpc_div.sv =====
// Pipelined unsigned 32 by 32 restoring divider, one quotient bit per stage.
// Depends on bpc_pkg for widths and the sideband size.
module bpc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [bpc_pkg::DIV_W-1:0]     in_num,
   input  logic [bpc_pkg::DIV_W-1:0]     in_den,
   input  logic [bpc_pkg::SIDE_W-1:0]    in_side,
   output logic                          out_valid,
   output logic [bpc_pkg::DIV_W-1:0]     out_quo,
   output logic [bpc_pkg::SIDE_W-1:0]    out_side
);

   localparam int W = bpc_pkg::DIV_W;
   localparam int N = bpc_pkg::DIV_STAGES;

   logic                      v_ff    [1:N];
   logic [W-1:0]              rem_ff  [1:N];
   logic [W-1:0]              quo_ff  [1:N];
   logic [W-1:0]              num_ff  [1:N];
   logic [W-1:0]              den_ff  [1:N];
   logic [bpc_pkg::SIDE_W-1:0] side_ff [1:N];

   for (genvar i = 0; i < N; i++) begin : g_stg
      logic                       v_p;
      logic [W-1:0]               rem_p, quo_p, num_p, den_p;
      logic [bpc_pkg::SIDE_W-1:0] side_p;
      logic [W:0]                 trial, diff;

      if (i == 0) begin : g_first
         assign v_p    = in_valid;
         assign rem_p  = '0;
         assign quo_p  = '0;
         assign num_p  = in_num;
         assign den_p  = in_den;
         assign side_p = in_side;
      end else begin : g_rest
         assign v_p    = v_ff[i];
         assign rem_p  = rem_ff[i];
         assign quo_p  = quo_ff[i];
         assign num_p  = num_ff[i];
         assign den_p  = den_ff[i];
         assign side_p = side_ff[i];
      end

      assign trial = {rem_p, num_p[W-1]};
      assign diff  = trial - {1'b0, den_p};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i+1]  <= diff[W] ? trial[W-1:0] : diff[W-1:0];
         quo_ff[i+1]  <= {quo_p[W-2:0], ~diff[W]};
         num_ff[i+1]  <= {num_p[W-2:0], 1'b0};
         den_ff[i+1]  <= den_p;
         side_ff[i+1] <= side_p;
      end
   end

   assign out_valid = v_ff[N];
   assign out_quo   = quo_ff[N];
   assign out_side  = side_ff[N];

endmodule

// ===== hdl/barometric_pressure_compensation.sv =====
// Barometric sensor compensation: raw pressure and temperature words in,
// temperature in tenths of a degree and pressure in pascals out.
// Depends on bpc_pkg, bpc_div and the assertion macro header.
//
// A word is taken in every cycle in which start is high; busy never rises.
// Each result appears on rsp_data with rsp_strobe high for one cycle,
// in order. The path is made of the two 32-stage dividers (temperature and
// pressure quotients, one bit per stage) plus ten arithmetic stages, each
// at most one multiplier deep. The receiver cannot stall, so nothing is ever
// held back. Calibration registers are written through the csr port; the user
// must write them only while no word is in flight, which the block does not enforce.
`include "barometric_pressure_compensation_assert.svh"

module barometric_pressure_compensation (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bpc_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output bpc_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   // Calibration registers.
   logic [15:0] cal_ac1_ff, cal_ac2_ff, cal_ac3_ff, cal_ac4_ff;
   logic [31:0] cal_ac5_ac6_ff, cal_b1_b2_ff, cal_mc_md_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ac1_ff     <= 16'd408;
         cal_ac2_ff     <= 16'hFFB8;
         cal_ac3_ff     <= 16'hC7D1;
         cal_ac4_ff     <= 16'd32741;
         cal_ac5_ac6_ff <= 32'd2146785905;
         cal_b1_b2_ff   <= 32'd405667844;
         cal_mc_md_ff   <= 32'd3724086068;
         oss_ff         <= 2'd0;
      end else if (csr_we) begin
         case (csr_index)
            bpc_pkg::CSR_AC1:     cal_ac1_ff     <= csr_wdata[15:0];
            bpc_pkg::CSR_AC2:     cal_ac2_ff     <= csr_wdata[15:0];
            bpc_pkg::CSR_AC3:     cal_ac3_ff     <= csr_wdata[15:0];
            bpc_pkg::CSR_AC4:     cal_ac4_ff     <= csr_wdata[15:0];
            bpc_pkg::CSR_AC5_AC6: cal_ac5_ac6_ff <= csr_wdata;
            bpc_pkg::CSR_B1_B2:   cal_b1_b2_ff   <= csr_wdata;
            bpc_pkg::CSR_MC_MD:   cal_mc_md_ff   <= csr_wdata;
            bpc_pkg::CSR_OSS:     oss_ff         <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = {{16{cal_ac1_ff[15]}}, cal_ac1_ff};
   assign ac2 = {{16{cal_ac2_ff[15]}}, cal_ac2_ff};
   assign ac3 = {{16{cal_ac3_ff[15]}}, cal_ac3_ff};
   assign ac4 = {16'd0, cal_ac4_ff};
   assign ac5 = {16'd0, cal_ac5_ac6_ff[31:16]};
   assign ac6 = {16'd0, cal_ac5_ac6_ff[15:0]};
   assign b1  = {{16{cal_b1_b2_ff[31]}}, cal_b1_b2_ff[31:16]};
   assign b2  = {{16{cal_b1_b2_ff[15]}}, cal_b1_b2_ff[15:0]};
   assign mc  = {{16{cal_mc_md_ff[31]}}, cal_mc_md_ff[31:16]};
   assign md  = {{16{cal_mc_md_ff[15]}}, cal_mc_md_ff[15:0]};

   logic accept;
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // Stage 1: first temperature term.
   logic        s1_v_ff;
   logic [31:0] s1_x1_ff, s1_x1_in, s1_prod;
   logic [18:0] s1_up_ff;
   assign s1_prod  = ({16'd0, req_data.raw_temperature} - ac6) * ac5;
   assign s1_x1_in = bpc_pkg::asr(s1_prod, 5'd15);

   always_ff @(posedge clock) begin
      s1_x1_ff <= s1_x1_in;
      s1_up_ff <= req_data.raw_pressure;
   end

   // Temperature divider, signed operands handled as magnitudes.
   logic [31:0]          d1_num, d1_den, d1_num_abs, d1_den_abs, d1_quo;
   bpc_pkg::tside_type   d1_side_in, d1_side_out;
   logic [bpc_pkg::SIDE_W-1:0] d1_side_vec;
   logic                 d1_v;
   assign d1_num     = {mc[26:0], 5'd0} << 6;
   assign d1_den     = s1_x1_ff + md;
   assign d1_num_abs = d1_num[31] ? 32'd0 - d1_num : d1_num;
   assign d1_den_abs = d1_den[31] ? 32'd0 - d1_den : d1_den;
   always_comb begin
      d1_side_in      = '0;
      d1_side_in.x1   = s1_x1_ff;
      d1_side_in.up   = s1_up_ff;
      d1_side_in.neg  = d1_num[31] ^ d1_den[31];
      d1_side_in.zero = (d1_den == 32'd0);
   end

   bpc_div u_div_t (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_v_ff),
      .in_num   (d1_num_abs),
      .in_den   (d1_den_abs),
      .in_side  (d1_side_in),
      .out_valid(d1_v),
      .out_quo  (d1_quo),
      .out_side (d1_side_vec)
   );
   assign d1_side_out = bpc_pkg::tside_type'(d1_side_vec);

   // Stage 3: B5.
   logic        s3_v_ff, s3_tz_ff;
   logic [31:0] s3_b5_ff, s3_x2;
   logic [18:0] s3_up_ff;
   assign s3_x2 = d1_side_out.zero ? 32'd0 :
                  d1_side_out.neg  ? 32'd0 - d1_quo : d1_quo;
   always_ff @(posedge clock) begin
      s3_b5_ff <= d1_side_out.x1 + s3_x2;
      s3_tz_ff <= d1_side_out.zero;
      s3_up_ff <= d1_side_out.up;
   end

   // Stage 4: B6, its square and the saturated temperature.
   logic        s4_v_ff, s4_tz_ff;
   logic [31:0] s4_b6_ff, s4_sq_ff, s4_b6_in, s4_t;
   logic [15:0] s4_temp_ff, s4_temp_in;
   logic [18:0] s4_up_ff;
   assign s4_b6_in = s3_b5_ff - 32'd4000;
   assign s4_t     = bpc_pkg::asr(s3_b5_ff + 32'd8, 5'd4);
   always_comb begin
      if ($signed(s4_t) > 32'sd32767) begin
         s4_temp_in = 16'h7FFF;
      end else if ($signed(s4_t) < -32'sd32768) begin
         s4_temp_in = 16'h8000;
      end else begin
         s4_temp_in = s4_t[15:0];
      end
   end
   always_ff @(posedge clock) begin
      s4_b6_ff   <= s4_b6_in;
      s4_sq_ff   <= bpc_pkg::asr(32'(s4_b6_in * s4_b6_in), 5'd12);
      s4_temp_ff <= s4_temp_in;
      s4_tz_ff   <= s3_tz_ff;
      s4_up_ff   <= s3_up_ff;
   end

   // Stage 5: the four coefficient products.
   logic        s5_v_ff, s5_tz_ff;
   logic [31:0] s5_m1_ff, s5_m2_ff, s5_m3_ff, s5_m4_ff;
   logic [15:0] s5_temp_ff;
   logic [18:0] s5_up_ff;
   always_ff @(posedge clock) begin
      s5_m1_ff   <= bpc_pkg::asr(32'(b2 * s4_sq_ff), 5'd11);
      s5_m2_ff   <= bpc_pkg::asr(32'(ac2 * s4_b6_ff), 5'd11);
      s5_m3_ff   <= bpc_pkg::asr(32'(ac3 * s4_b6_ff), 5'd13);
      s5_m4_ff   <= bpc_pkg::asr(32'(b1 * s4_sq_ff), 5'd16);
      s5_temp_ff <= s4_temp_ff;
      s5_tz_ff   <= s4_tz_ff;
      s5_up_ff   <= s4_up_ff;
   end

   // Stage 6: B3 and the B4 operand.
   logic        s6_v_ff, s6_tz_ff;
   logic [31:0] s6_b3_ff, s6_b4v_ff, s6_x3a, s6_x3b;
   logic [15:0] s6_temp_ff;
   logic [18:0] s6_up_ff;
   assign s6_x3a = s5_m1_ff + s5_m2_ff;
   assign s6_x3b = bpc_pkg::asr(s5_m3_ff + s5_m4_ff + 32'd2, 5'd2);
   always_ff @(posedge clock) begin
      s6_b3_ff   <= bpc_pkg::asr((((ac1 << 2) + s6_x3a) << oss_ff) + 32'd2, 5'd2);
      s6_b4v_ff  <= s6_x3b + 32'd32768;
      s6_temp_ff <= s5_temp_ff;
      s6_tz_ff   <= s5_tz_ff;
      s6_up_ff   <= s5_up_ff;
   end

   // Stage 7: B4 and B7, both unsigned.
   logic        s7_v_ff, s7_tz_ff;
   logic [31:0] s7_b4_ff, s7_b7_ff, s7_b4_prod;
   logic [15:0] s7_temp_ff;
   assign s7_b4_prod = ac4 * s6_b4v_ff;
   always_ff @(posedge clock) begin
      s7_b4_ff   <= s7_b4_prod >> 15;
      s7_b7_ff   <= ({13'd0, s6_up_ff} - s6_b3_ff) * (32'd50000 >> oss_ff);
      s7_temp_ff <= s6_temp_ff;
      s7_tz_ff   <= s6_tz_ff;
   end

   // Pressure divider. A large B7 is divided unshifted and doubled afterwards.
   logic [31:0]          d2_num, d2_quo;
   bpc_pkg::pside_type   d2_side_in, d2_side_out;
   logic [bpc_pkg::SIDE_W-1:0] d2_side_vec;
   logic                 d2_v;
   assign d2_num = s7_b7_ff[31] ? s7_b7_ff : {s7_b7_ff[30:0], 1'b0};
   always_comb begin
      d2_side_in        = '0;
      d2_side_in.temp   = s7_temp_ff;
      d2_side_in.t_zero = s7_tz_ff;
      d2_side_in.big    = s7_b7_ff[31];
      d2_side_in.p_zero = (s7_b4_ff == 32'd0);
   end

   bpc_div u_div_p (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s7_v_ff),
      .in_num   (d2_num),
      .in_den   (s7_b4_ff),
      .in_side  (d2_side_in),
      .out_valid(d2_v),
      .out_quo  (d2_quo),
      .out_side (d2_side_vec)
   );
   assign d2_side_out = bpc_pkg::pside_type'(d2_side_vec);

   // Stage 8: raw pressure quotient.
   logic        s8_v_ff, s8_st_ff, s8_pz_ff;
   logic [31:0] s8_p_ff;
   logic [15:0] s8_temp_ff;
   always_ff @(posedge clock) begin
      s8_p_ff    <= d2_side_out.p_zero ? 32'd0 :
                    d2_side_out.big    ? {d2_quo[30:0], 1'b0} : d2_quo;
      s8_st_ff   <= d2_side_out.t_zero | d2_side_out.p_zero;
      s8_pz_ff   <= d2_side_out.p_zero;
      s8_temp_ff <= d2_side_out.temp;
   end

   // Stage 9: square of the scaled pressure and the linear term.
   logic        s9_v_ff, s9_st_ff;
   logic [31:0] s9_p_ff, s9_sq_ff, s9_x2_ff, s9_ps;
   logic [15:0] s9_temp_ff;
   assign s9_ps = bpc_pkg::asr(s8_p_ff, 5'd8);
   always_ff @(posedge clock) begin
      s9_sq_ff   <= s9_ps * s9_ps;
      s9_x2_ff   <= bpc_pkg::asr(32'd0 - 32'(32'd7357 * s8_p_ff), 5'd16);
      s9_p_ff    <= s8_p_ff;
      s9_st_ff   <= s8_st_ff;
      s9_temp_ff <= s8_temp_ff;
   end

   // Stage 10: quadratic term.
   logic        s10_v_ff, s10_st_ff;
   logic [31:0] s10_p_ff, s10_x1_ff, s10_x2_ff;
   logic [15:0] s10_temp_ff;
   always_ff @(posedge clock) begin
      s10_x1_ff   <= bpc_pkg::asr(32'(s9_sq_ff * 32'd3038), 5'd16);
      s10_x2_ff   <= s9_x2_ff;
      s10_p_ff    <= s9_p_ff;
      s10_st_ff   <= s9_st_ff;
      s10_temp_ff <= s9_temp_ff;
   end

   // Stage 11: correction, saturation and the result register.
   logic [31:0]      s11_pf;
   bpc_pkg::rsp_type rsp_in, rsp_ff;
   logic             s11_v_ff;
   assign s11_pf = s10_p_ff + bpc_pkg::asr(s10_x1_ff + s10_x2_ff + 32'd3791, 5'd4);
   always_comb begin
      rsp_in.temp_tenths = s10_temp_ff;
      rsp_in.status      = s10_st_ff;
      if (s11_pf[31]) begin
         rsp_in.pressure_pa = 20'd0;
      end else if (s11_pf > 32'd1048575) begin
         rsp_in.pressure_pa = 20'hFFFFF;
      end else begin
         rsp_in.pressure_pa = s11_pf[19:0];
      end
   end
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Valid bits for the arithmetic stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         s6_v_ff  <= 1'b0;
         s7_v_ff  <= 1'b0;
         s8_v_ff  <= 1'b0;
         s9_v_ff  <= 1'b0;
         s10_v_ff <= 1'b0;
         s11_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= accept;
         s3_v_ff  <= d1_v;
         s4_v_ff  <= s3_v_ff;
         s5_v_ff  <= s4_v_ff;
         s6_v_ff  <= s5_v_ff;
         s7_v_ff  <= s6_v_ff;
         s8_v_ff  <= d2_v;
         s9_v_ff  <= s8_v_ff;
         s10_v_ff <= s9_v_ff;
         s11_v_ff <= s10_v_ff;
      end
   end

   assign rsp_strobe = s11_v_ff;
   assign rsp_data   = rsp_ff;

   // A result only ever follows an accepted word by the fixed latency.
   `BPC_ASSERT_NOW(a_latency, clock, reset, rsp_strobe, $past(accept, bpc_pkg::LATENCY))
   // The temperature divider keeps its word count in step.
   `BPC_ASSERT_NOW(a_div_t_lat, clock, reset, s3_v_ff,
                   $past(s1_v_ff, bpc_pkg::DIV_STAGES + 1))
   // A zero pressure divisor flags the result and leaves only the constant term.
   `BPC_ASSERT_NOW(a_pzero, clock, reset, rsp_strobe && $past(s8_pz_ff, 3),
                   rsp_data.status && (rsp_data.pressure_pa == 20'd236))

endmodule

// ===== tb/sv/tb_barometric_pressure_compensation.sv =====
// Self-checking testbench for barometric_pressure_compensation.
// Depends on bpc_pkg and the block's RTL; expected words come from an in-file
// integer predictor of the compensation arithmetic or from typed stimulus rows.
`default_nettype none

module tb_barometric_pressure_compensation;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_WORDS = 240;

   typedef enum int {CAL_RESET, CAL_ZERO, CAL_MAX, CAL_MIN, CAL_RANDOM} cal_mode_type;

   typedef struct {
      bpc_pkg::req_type word;
      bit               typed;
      bpc_pkg::rsp_type rsp;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   bpc_pkg::req_type req_data;
   logic    rsp_strobe;
   bpc_pkg::rsp_type rsp_data;
   logic    csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   logic [31:0]      cal_regs [8];
   bpc_pkg::rsp_type pending_results [$];
   int               error_count = 0;
   int               cycles = 0;

   barometric_pressure_compensation uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_barometric_pressure_compensation: errors");
         $finish;
      end
   end

   function automatic logic [31:0] shift_arith(input logic [31:0] v, input int n);
      logic signed [31:0] s;
      s = v;
      return s >>> n;
   endfunction

   function automatic logic [31:0] sign_ext16(input logic [31:0] v);
      return {{16{v[15]}}, v[15:0]};
   endfunction

   // Integer compensation with 32-bit wrapping terms throughout.
   function automatic bpc_pkg::rsp_type compensate(input bpc_pkg::req_type w);
      logic [31:0] up, ut, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, sq, t, p, tmp, den;
      logic [1:0]  oss;
      bit          zero;
      longint      tv, pv;
      bpc_pkg::rsp_type r;
      up  = {13'd0, w.raw_pressure};
      ut  = {16'd0, w.raw_temperature};
      ac1 = sign_ext16(cal_regs[bpc_pkg::CSR_AC1]);
      ac2 = sign_ext16(cal_regs[bpc_pkg::CSR_AC2]);
      ac3 = sign_ext16(cal_regs[bpc_pkg::CSR_AC3]);
      ac4 = {16'd0, cal_regs[bpc_pkg::CSR_AC4][15:0]};
      ac5 = {16'd0, cal_regs[bpc_pkg::CSR_AC5_AC6][31:16]};
      ac6 = {16'd0, cal_regs[bpc_pkg::CSR_AC5_AC6][15:0]};
      b1  = sign_ext16(cal_regs[bpc_pkg::CSR_B1_B2] >> 16);
      b2  = sign_ext16(cal_regs[bpc_pkg::CSR_B1_B2]);
      mc  = sign_ext16(cal_regs[bpc_pkg::CSR_MC_MD] >> 16);
      md  = sign_ext16(cal_regs[bpc_pkg::CSR_MC_MD]);
      oss = cal_regs[bpc_pkg::CSR_OSS][1:0];
      zero = 0;

      tmp = ut - ac6;
      tmp = tmp * ac5;
      x1 = shift_arith(tmp, 15);
      den = x1 + md;
      tmp = mc << 11;
      if (den == 32'd0) begin
         zero = 1;
         x2 = 32'd0;
      end else begin
         // Quotient taken in 64 bits so that the most negative value over -1 wraps.
         x2 = 32'(longint'($signed(tmp)) / longint'($signed(den)));
      end
      b5 = x1 + x2;
      t = shift_arith(b5 + 32'd8, 4);

      b6 = b5 - 32'd4000;
      tmp = b6 * b6;
      sq = shift_arith(tmp, 12);
      tmp = b2 * sq;
      x1 = shift_arith(tmp, 11);
      tmp = ac2 * b6;
      x2 = shift_arith(tmp, 11);
      x3 = x1 + x2;
      tmp = (ac1 * 32'd4 + x3) << oss;
      b3 = shift_arith(tmp + 32'd2, 2);

      tmp = ac3 * b6;
      x1 = shift_arith(tmp, 13);
      tmp = b1 * sq;
      x2 = shift_arith(tmp, 16);
      x3 = shift_arith(x1 + x2 + 32'd2, 2);
      tmp = ac4 * (x3 + 32'd32768);
      b4 = tmp >> 15;

      tmp = up - b3;
      b7 = tmp * (32'd50000 >> oss);
      if (b4 == 32'd0) begin
         zero = 1;
         p = 32'd0;
      end else if (b7 < 32'h8000_0000) begin
         p = (b7 << 1) / b4;
      end else begin
         p = (b7 / b4) << 1;
      end
      tmp = shift_arith(p, 8);
      x1 = tmp * tmp;
      tmp = x1 * 32'd3038;
      x1 = shift_arith(tmp, 16);
      tmp = 32'd0 - 32'd7357 * p;
      x2 = shift_arith(tmp, 16);
      p = p + shift_arith(x1 + x2 + 32'd3791, 4);

      tv = longint'($signed(t));
      if (tv > 32767) tv = 32767;
      if (tv < -32768) tv = -32768;
      pv = longint'($signed(p));
      if (pv > 1048575) pv = 1048575;
      if (pv < 0) pv = 0;
      r.temp_tenths = tv[15:0];
      r.pressure_pa = pv[19:0];
      r.status      = zero;
      return r;
   endfunction

   // Each strobed word is checked against the oldest outstanding prediction.
   always @(posedge clock) begin
      bpc_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.temp_tenths !== want.temp_tenths) begin
               $display("%0t: temp_tenths expected %0d actual %0d", $time,
                        want.temp_tenths, rsp_data.temp_tenths);
               error_count++;
            end
            if (rsp_data.pressure_pa !== want.pressure_pa) begin
               $display("%0t: pressure_pa expected %0d actual %0d", $time,
                        want.pressure_pa, rsp_data.pressure_pa);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   // Called at a rising edge; start is left high after acceptance so that a
   // back-to-back word needs no second assignment in the same step.
   task automatic send_word(input bpc_pkg::req_type w, input int gap, input bit typed,
                            input bpc_pkg::rsp_type typed_rsp);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      pending_results.push_back(typed ? typed_rsp : compensate(w));
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (bpc_pkg::LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      cal_regs[idx] = val;
      @(posedge clock);
   endtask

   // Leaves the write enable high; the caller drops it once its writes are done.
   task automatic program_cal(input cal_mode_type mode);
      logic [31:0] v [8];
      case (mode)
         CAL_RESET: begin
            v = '{32'd408, 32'hFFB8, 32'hC7D1, 32'd32741,
                  32'd2146785905, 32'd405667844, 32'd3724086068, 32'd0};
         end
         CAL_ZERO: begin
            v = '{default: 32'd0};
         end
         CAL_MAX: begin
            v = '{32'h7FFF, 32'h7FFF, 32'h7FFF, 32'hFFFF,
                  32'hFFFF_FFFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'd3};
         end
         CAL_MIN: begin
            v = '{32'h8000, 32'h8000, 32'h8000, 32'h0,
                  32'h0, 32'h8000_8000, 32'h8000_8000, 32'd0};
         end
         default: begin
            foreach (v[i]) v[i] = $urandom;
            v[bpc_pkg::CSR_OSS] = $urandom_range(0, 3);
         end
      endcase
      foreach (v[i]) write_reg(3'(i), v[i]);
   endtask

   stim_row_type directed [] = '{
      '{'{19'd0, 16'd0}, 0, '0},
      '{'{19'h7FFFF, 16'hFFFF}, 0, '0},
      '{'{19'd0, 16'hFFFF}, 0, '0},
      '{'{19'h7FFFF, 16'd0}, 0, '0},
      '{'{19'd23843, 16'd27898}, 0, '0},
      '{'{19'h55555, 16'h5555}, 0, '0},
      '{'{19'h2AAAA, 16'hAAAA}, 0, '0},
      '{'{19'd1, 16'd1}, 0, '0},
      '{'{19'h40000, 16'h8000}, 0, '0}
   };

   // With every calibration word zero both divisors vanish: temperature 0,
   // pressure is the bare correction constant, and the error flag is raised.
   stim_row_type zero_cal [] = '{
      '{'{19'd0, 16'd0}, 1, '{16'sd0, 20'd236, 1'b1}},
      '{'{19'h7FFFF, 16'hFFFF}, 1, '{16'sd0, 20'd236, 1'b1}},
      '{'{19'h2AAAA, 16'h5555}, 1, '{16'sd0, 20'd236, 1'b1}}
   };

   initial begin
      bpc_pkg::req_type w;
      cal_mode_type mode;
      int gap;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      reset     <= 1'b1;
      cal_regs = '{32'd408, 32'hFFB8, 32'hC7D1, 32'd32741,
                   32'd2146785905, 32'd405667844, 32'd3724086068, 32'd0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_word(directed[i].word, i % 3, directed[i].typed, directed[i].rsp);
      wait_idle();
      program_cal(CAL_ZERO);
      csr_we <= 1'b0;
      foreach (zero_cal[i])
         send_word(zero_cal[i].word, 0, zero_cal[i].typed, zero_cal[i].rsp);
      wait_idle();

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: mode = CAL_RESET;
            1: mode = CAL_MAX;
            2: mode = CAL_MIN;
            default: mode = CAL_RANDOM;
         endcase
         program_cal(mode);
         if (ph == 0) write_reg(bpc_pkg::CSR_OSS, 32'd3);
         csr_we <= 1'b0;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            w.raw_pressure    = 19'($urandom);
            w.raw_temperature = 16'($urandom);
            case ($urandom_range(0, 9))
               0: w.raw_pressure = '1;
               1: w.raw_pressure = '0;
               2: w.raw_temperature = '1;
               3: w.raw_temperature = '0;
               default: ;
            endcase
            // Alternate phases run mostly back to back.
            if (ph % 2 == 1 && $urandom_range(0, 3) != 0) gap = 0;
            else gap = $urandom_range(0, 16);
            if (n == PHASE_WORDS / 2 && ph == 4) begin
               start <= 1'b0;
               while (pending_results.size() != 0) @(posedge clock);
            end
            send_word(w, gap, 0, '0);
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("tb_barometric_pressure_compensation: clean");
      end else begin
         $display("tb_barometric_pressure_compensation: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
